// File: rtl/ohci_root_hub_register_block_top_assert.svh
// Assertion macros for the root hub register block.
// Both expect a clock named clk in scope; OHCI_RH_ASSERT also expects a reset named arst_n.
`ifndef OHCI_ROOT_HUB_REGISTER_BLOCK_TOP_ASSERT_SVH
`define OHCI_ROOT_HUB_REGISTER_BLOCK_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define OHCI_RH_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("ohci_rh: assertion failed");
`define OHCI_RH_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
	else $error("ohci_rh: assertion failed");
`else
`define OHCI_RH_ASSERT(lbl, prop)
`define OHCI_RH_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// File: rtl/ohci_rh_pkg.sv
package ohci_rh_pkg;

	localparam int STORE_BYTES = 4096;
	localparam int ADDR_W      = $clog2(STORE_BYTES);

	typedef logic [ADDR_W-1:0] addr_t;

	// One bus transaction as seen by the register and memory parts
	typedef struct packed {
		logic       acc;
		logic       wr;
		logic [11:0] ofs;
		logic [7:0] data;
	} rh_access_t;

	typedef struct packed {
		logic [7:0] cur;
		logic [7:0] chg;
	} port_upd_t;

	localparam logic [11:0] OFS_REV      = 12'h000;
	localparam logic [11:0] OFS_REV1     = 12'h001;
	localparam logic [11:0] OFS_CTRL     = 12'h004;
	localparam logic [11:0] OFS_CMD      = 12'h008;
	localparam logic [11:0] OFS_INT_ST   = 12'h00c;
	localparam logic [11:0] OFS_INT_ST3  = 12'h00f;
	localparam logic [11:0] OFS_INT_EN   = 12'h00d;
	localparam logic [11:0] OFS_INT_EN2  = 12'h00e;
	localparam logic [11:0] OFS_FM_INT1  = 12'h039;
	localparam logic [11:0] OFS_FM_RO2   = 12'h03a;
	localparam logic [11:0] OFS_FM_INT3  = 12'h03b;
	localparam logic [11:0] OFS_FM_RO6   = 12'h03e;
	localparam logic [11:0] OFS_FM_RO7   = 12'h03f;
	localparam logic [11:0] OFS_PER1     = 12'h041;
	localparam logic [11:0] OFS_PER_RO2  = 12'h042;
	localparam logic [11:0] OFS_PER_RO3  = 12'h043;
	localparam logic [11:0] OFS_LS1      = 12'h045;
	localparam logic [11:0] OFS_LS_RO2   = 12'h046;
	localparam logic [11:0] OFS_LS_RO3   = 12'h047;
	localparam logic [11:0] OFS_DESC_A0  = 12'h048;
	localparam logic [11:0] OFS_DESC_A1  = 12'h049;
	localparam logic [11:0] OFS_DESC_A2  = 12'h04a;
	localparam logic [11:0] OFS_DESC_A3  = 12'h04b;
	localparam logic [11:0] OFS_DESC_B0  = 12'h04c;
	localparam logic [11:0] OFS_DESC_B1  = 12'h04d;
	localparam logic [11:0] OFS_DESC_B2  = 12'h04e;
	localparam logic [11:0] OFS_DESC_B3  = 12'h04f;
	localparam logic [11:0] OFS_HUB_ST0  = 12'h050;
	localparam logic [11:0] OFS_HUB_ST1  = 12'h051;
	localparam logic [11:0] OFS_HUB_ST2  = 12'h052;
	localparam logic [11:0] OFS_HUB_ST3  = 12'h053;
	localparam logic [11:0] OFS_P1_ST    = 12'h054;
	localparam logic [11:0] OFS_P1_PWR   = 12'h055;
	localparam logic [11:0] OFS_P1_CHG   = 12'h056;
	localparam logic [11:0] OFS_P1_RO    = 12'h057;
	localparam logic [11:0] OFS_P2_ST    = 12'h058;
	localparam logic [11:0] OFS_P2_PWR   = 12'h059;
	localparam logic [11:0] OFS_P2_CHG   = 12'h05a;
	localparam logic [11:0] OFS_P2_RO    = 12'h05b;

	localparam logic [1:0] MODE_GANGED  = 2'd0;
	localparam logic [1:0] MODE_PERPORT = 2'd1;

	function automatic logic is_hc_reset(rh_access_t a);
		return a.acc && a.wr && (a.ofs == OFS_CMD) && a.data[0];
	endfunction

	// Bytes that live in flops because logic reads or modifies them
	function automatic logic is_flop_addr(logic [11:0] a);
		case (a)
			OFS_INT_ST, OFS_INT_ST3, OFS_DESC_A1, OFS_DESC_B2, OFS_HUB_ST1,
			OFS_HUB_ST2, OFS_P1_ST, OFS_P1_PWR, OFS_P1_CHG, OFS_P2_ST,
			OFS_P2_PWR, OFS_P2_CHG: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	// Plain or masked stores that go to the memory
	function automatic logic mem_write_ok(logic [11:0] a);
		case (a)
			OFS_INT_EN, OFS_INT_EN2, OFS_FM_RO2, OFS_FM_RO6, OFS_FM_RO7,
			OFS_PER_RO2, OFS_PER_RO3, OFS_LS_RO2, OFS_LS_RO3, OFS_DESC_A0,
			OFS_DESC_A2, OFS_DESC_B1, OFS_DESC_B3, OFS_P1_RO, OFS_P2_RO,
			OFS_HUB_ST0, OFS_HUB_ST3: return 1'b0;
			default: return !is_flop_addr(a);
		endcase
	endfunction

	function automatic logic [7:0] mem_wval(logic [11:0] a, logic [7:0] v);
		case (a)
			OFS_FM_INT1, OFS_PER1: return v & 8'h3f;
			OFS_FM_INT3:           return v & 8'h80;
			OFS_LS1:               return v & 8'h0f;
			OFS_DESC_A3:           return v & 8'h03;
			OFS_DESC_B0:           return v & 8'h06;
			default:               return v;
		endcase
	endfunction

	function automatic logic [7:0] default_byte(addr_t a);
		case (a)
			addr_t'(OFS_REV):     return 8'h10;
			addr_t'(OFS_REV1):    return 8'h01;
			addr_t'(OFS_DESC_A0): return 8'h02;
			default:              return 8'h00;
		endcase
	endfunction

	function automatic port_upd_t port_command(logic [7:0] old, logic [7:0] chg,
			logic [7:0] v);
		port_upd_t r;
		r.cur = old;
		r.chg = chg;
		if (v[4]) begin
			if (old[0]) r.chg[4] = 1'b1;
			else r.chg[0] = 1'b1;
		end
		if (v[3]) r.cur[2] = 1'b0;
		if (v[2]) r.cur[2] = 1'b1;
		if (v[1]) begin
			if (old[0]) r.cur[1] = 1'b1;
			else r.chg[0] = 1'b1;
		end
		if (v[0]) begin
			if (old[0]) r.cur[1] = 1'b0;
			else r.chg[0] = 1'b1;
		end
		if (!r.cur[2] && old[2]) r.chg[2] = 1'b1;
		return r;
	endfunction

endpackage

// File: rtl/ohci_rh_req_if.sv
interface ohci_rh_req_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [11:0] offset;
	logic [7:0]  write_byte;

	modport source (output valid, command, offset, write_byte, input ready);
	modport sink (input valid, command, offset, write_byte, output ready);
endinterface

// File: rtl/ohci_rh_rsp_if.sv
interface ohci_rh_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_byte;

	modport source (output valid, read_byte, input ready);
	modport sink (input valid, read_byte, output ready);
endinterface

// File: rtl/ohci_root_hub_register_block_top.sv
// Root hub register block: byte-wide register window of a small USB host
// controller with two root-hub ports.
// req channel: one byte access per transaction (command 0 read, 1 write,
// 12-bit offset, write_byte). rsp channel: one read_byte per request,
// the stored byte for reads and zero for writes, in request order.
// rsp.valid rises in the cycle after request acceptance; one request
// per cycle is sustained while rsp is taken and no sweep runs. Flop-backed
// status bytes and the 4096-byte store are updated at the acceptance edge.
// After reset, and after a write to the command byte with its reset bit,
// the store is swept back to its defaults one byte per cycle with req.ready
// low throughout. The result of the resetting write is still delivered.
// When rsp stalls, the result stays in its register; req.ready follows
// rsp.ready so one further request is taken only as the result leaves.
`include "ohci_root_hub_register_block_top_assert.svh"
module ohci_root_hub_register_block_top (
	input  logic                clk,
	input  logic                arst_n,
	ohci_rh_req_if.sink         req,
	ohci_rh_rsp_if.source       rsp
);

	ohci_rh_pkg::rh_access_t acc;
	logic       busy;
	logic       rd_hit;
	logic [7:0] rd_byte;
	logic [7:0] mem_rdata;
	logic       valid_s1;
	logic       memsel_s1;
	logic [7:0] byte_s1;

	assign req.ready = !busy && (!valid_s1 || rsp.ready);
	assign acc.acc   = req.valid && req.ready;
	assign acc.wr    = req.command;
	assign acc.ofs   = req.offset;
	assign acc.data  = req.write_byte;

	ohci_rh_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.acc     (acc),
		.rd_hit  (rd_hit),
		.rd_byte (rd_byte)
	);

	ohci_rh_mem u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.acc    (acc),
		.busy   (busy),
		.rdata  (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (acc.acc) begin
			valid_s1 <= 1'b1;
		end else if (rsp.ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc.acc) begin
			memsel_s1 <= !req.command && !rd_hit;
			byte_s1   <= req.command ? 8'h00 : rd_byte;
		end
	end

	assign rsp.valid     = valid_s1;
	assign rsp.read_byte = memsel_s1 ? mem_rdata : byte_s1;

	`OHCI_RH_ASSERT_ALWAYS(a_no_accept_in_sweep, busy |-> !req.ready)
	`OHCI_RH_ASSERT(a_write_reads_zero, acc.acc && acc.wr |=> rsp.valid && rsp.read_byte == 8'h00)
	`OHCI_RH_ASSERT(a_hc_reset_sweeps, ohci_rh_pkg::is_hc_reset(acc) |=> busy)
	`OHCI_RH_ASSERT(a_result_follows, acc.acc |=> valid_s1)

endmodule

// File: rtl/ohci_rh_regs.sv
module ohci_rh_regs (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ohci_rh_pkg::rh_access_t acc,
	output logic                    rd_hit,
	output logic [7:0]              rd_byte
);

	logic [7:0] int_st_q, int_st3_q, desc_a1_q, desc_b2_q, hub1_q, hub2_q;
	logic [7:0] p1_st_q, p1_pwr_q, p1_chg_q, p2_st_q, p2_pwr_q, p2_chg_q;
	logic [7:0] int_st_d, int_st3_d, desc_a1_d, desc_b2_d, hub1_d, hub2_d;
	logic [7:0] p1_st_d, p1_pwr_d, p1_chg_d, p2_st_d, p2_pwr_d, p2_chg_d;
	logic [1:0] mode;
	logic [7:0] v;
	ohci_rh_pkg::port_upd_t upd;
	logic       off1, off2;

	assign mode = desc_a1_q[1:0];
	assign v    = acc.data;

	always_comb begin
		int_st_d  = int_st_q;
		int_st3_d = int_st3_q;
		desc_a1_d = desc_a1_q;
		desc_b2_d = desc_b2_q;
		hub1_d    = hub1_q;
		hub2_d    = hub2_q;
		p1_st_d   = p1_st_q;
		p1_pwr_d  = p1_pwr_q;
		p1_chg_d  = p1_chg_q;
		p2_st_d   = p2_st_q;
		p2_pwr_d  = p2_pwr_q;
		p2_chg_d  = p2_chg_q;
		upd       = '0;
		off1      = 1'b0;
		off2      = 1'b0;
		if (acc.acc && acc.wr) begin
			case (acc.ofs)
				ohci_rh_pkg::OFS_CTRL: begin
					if (v[7:6] == 2'b00) begin
						p1_chg_d = 8'h16;
						p2_chg_d = 8'h16;
					end
				end
				ohci_rh_pkg::OFS_CMD: begin
					if (v[3]) int_st3_d = 8'h40;
				end
				ohci_rh_pkg::OFS_INT_ST:  int_st_d = int_st_q & ~(v & 8'h7f);
				ohci_rh_pkg::OFS_INT_ST3: int_st3_d = int_st3_q & ~(v & 8'h40);
				ohci_rh_pkg::OFS_DESC_A1: begin
					desc_a1_d = v & 8'h1b;
					if (v[1]) begin
						p1_pwr_d[0] = 1'b1;
						p2_pwr_d[0] = 1'b1;
					end
				end
				ohci_rh_pkg::OFS_DESC_B0: begin
					if (!v[2]) begin
						if (!p2_st_q[0]) p2_chg_d[0] = 1'b1;
						p2_st_d[0] = 1'b1;
					end
					if (!v[1]) begin
						if (!p1_st_q[0]) p1_chg_d[0] = 1'b1;
						p1_st_d[0] = 1'b1;
					end
				end
				ohci_rh_pkg::OFS_DESC_B2: desc_b2_d = v & 8'h06;
				ohci_rh_pkg::OFS_HUB_ST0: begin
					if (v[0]) begin
						if (mode == ohci_rh_pkg::MODE_GANGED) begin
							off1 = 1'b1;
							off2 = 1'b1;
						end else if (mode == ohci_rh_pkg::MODE_PERPORT) begin
							off1 = !desc_b2_q[1];
							off2 = !desc_b2_q[2];
						end
					end
				end
				ohci_rh_pkg::OFS_HUB_ST1: if (v[7]) hub1_d[7] = 1'b1;
				ohci_rh_pkg::OFS_HUB_ST2: begin
					hub2_d = hub2_q & ~(v & 8'h02);
					if (v[0]) begin
						if (mode == ohci_rh_pkg::MODE_GANGED) begin
							p1_pwr_d[0] = 1'b1;
							p2_pwr_d[0] = 1'b1;
						end else if (mode == ohci_rh_pkg::MODE_PERPORT) begin
							if (!desc_b2_q[1]) p1_pwr_d[0] = 1'b1;
							if (!desc_b2_q[2]) p2_pwr_d[0] = 1'b1;
						end
					end
				end
				ohci_rh_pkg::OFS_HUB_ST3: if (v[7]) hub1_d[7] = 1'b0;
				ohci_rh_pkg::OFS_P1_ST: begin
					upd = ohci_rh_pkg::port_command(p1_st_q, p1_chg_q, v);
					p1_st_d  = upd.cur;
					p1_chg_d = upd.chg;
				end
				ohci_rh_pkg::OFS_P2_ST: begin
					upd = ohci_rh_pkg::port_command(p2_st_q, p2_chg_q, v);
					p2_st_d  = upd.cur;
					p2_chg_d = upd.chg;
				end
				ohci_rh_pkg::OFS_P1_PWR: begin
					if (mode == ohci_rh_pkg::MODE_GANGED && desc_b2_q[1]) begin
						off1 = v[1];
						if (v[0]) p1_pwr_d[0] = 1'b1;
					end
				end
				ohci_rh_pkg::OFS_P2_PWR: begin
					if (mode == ohci_rh_pkg::MODE_GANGED && desc_b2_q[2]) begin
						if (v[1]) p2_pwr_d[0] = 1'b0;
						if (v[0]) p2_pwr_d[0] = 1'b1;
					end
				end
				ohci_rh_pkg::OFS_P1_CHG: p1_chg_d = p1_chg_q & ~(v & 8'h1f);
				ohci_rh_pkg::OFS_P2_CHG: p2_chg_d = p2_chg_q & ~(v & 8'h1f);
				default: ;
			endcase
			// power off comes before a power-on bit of the same write
			if (off1) begin
				p1_st_d  = p1_st_q & ~8'h17;
				p1_chg_d = p1_chg_q & ~8'h17;
				p1_pwr_d = {p1_pwr_q[7:1], v[0] && acc.ofs == ohci_rh_pkg::OFS_P1_PWR};
			end
			if (off2) begin
				p2_st_d  = p2_st_q & ~8'h17;
				p2_chg_d = p2_chg_q & ~8'h17;
				p2_pwr_d = {p2_pwr_q[7:1], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			int_st_q  <= '0;
			int_st3_q <= '0;
			desc_a1_q <= '0;
			desc_b2_q <= '0;
			hub1_q    <= '0;
			hub2_q    <= '0;
			p1_st_q   <= '0;
			p1_pwr_q  <= '0;
			p1_chg_q  <= '0;
			p2_st_q   <= '0;
			p2_pwr_q  <= '0;
			p2_chg_q  <= '0;
		end else if (ohci_rh_pkg::is_hc_reset(acc)) begin
			int_st_q  <= '0;
			int_st3_q <= '0;
			desc_a1_q <= '0;
			desc_b2_q <= '0;
			hub1_q    <= '0;
			hub2_q    <= '0;
			p1_st_q   <= '0;
			p1_pwr_q  <= '0;
			p1_chg_q  <= '0;
			p2_st_q   <= '0;
			p2_pwr_q  <= '0;
			p2_chg_q  <= '0;
		end else begin
			int_st_q  <= int_st_d;
			int_st3_q <= int_st3_d;
			desc_a1_q <= desc_a1_d;
			desc_b2_q <= desc_b2_d;
			hub1_q    <= hub1_d;
			hub2_q    <= hub2_d;
			p1_st_q   <= p1_st_d;
			p1_pwr_q  <= p1_pwr_d;
			p1_chg_q  <= p1_chg_d;
			p2_st_q   <= p2_st_d;
			p2_pwr_q  <= p2_pwr_d;
			p2_chg_q  <= p2_chg_d;
		end
	end

	always_comb begin
		rd_hit = 1'b1;
		unique case (acc.ofs)
			ohci_rh_pkg::OFS_INT_ST:  rd_byte = int_st_q;
			ohci_rh_pkg::OFS_INT_ST3: rd_byte = int_st3_q;
			ohci_rh_pkg::OFS_DESC_A1: rd_byte = desc_a1_q;
			ohci_rh_pkg::OFS_DESC_B2: rd_byte = desc_b2_q;
			ohci_rh_pkg::OFS_HUB_ST1: rd_byte = hub1_q;
			ohci_rh_pkg::OFS_HUB_ST2: rd_byte = hub2_q;
			ohci_rh_pkg::OFS_P1_ST:   rd_byte = p1_st_q;
			ohci_rh_pkg::OFS_P1_PWR:  rd_byte = p1_pwr_q;
			ohci_rh_pkg::OFS_P1_CHG:  rd_byte = p1_chg_q;
			ohci_rh_pkg::OFS_P2_ST:   rd_byte = p2_st_q;
			ohci_rh_pkg::OFS_P2_PWR:  rd_byte = p2_pwr_q;
			ohci_rh_pkg::OFS_P2_CHG:  rd_byte = p2_chg_q;
			default: begin
				rd_hit  = 1'b0;
				rd_byte = '0;
			end
		endcase
	end

endmodule

// File: rtl/ohci_rh_mem.sv
module ohci_rh_mem (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ohci_rh_pkg::rh_access_t acc,
	output logic                    busy,
	output logic [7:0]              rdata
);

	logic [7:0]               mem [ohci_rh_pkg::STORE_BYTES];
	logic [7:0]               rdata_q;
	logic                     clr_q;
	ohci_rh_pkg::addr_t       clr_addr_q;
	logic [7:0]               cmd_byte_q;
	ohci_rh_pkg::addr_t       addr;
	logic                     wr_en;
	logic [7:0]               clr_val;

	assign addr  = acc.ofs[ohci_rh_pkg::ADDR_W-1:0];
	assign wr_en = acc.acc && acc.wr && ohci_rh_pkg::mem_write_ok(acc.ofs) &&
		!ohci_rh_pkg::is_hc_reset(acc);
	// the command byte written with the reset survives the sweep
	assign clr_val = (clr_addr_q == ohci_rh_pkg::addr_t'(ohci_rh_pkg::OFS_CMD)) ?
		cmd_byte_q : ohci_rh_pkg::default_byte(clr_addr_q);
	assign busy  = clr_q;
	assign rdata = rdata_q;

	always_ff @(posedge clk) begin
		if (clr_q) begin
			mem[clr_addr_q] <= clr_val;
		end else if (wr_en) begin
			mem[addr] <= ohci_rh_pkg::mem_wval(acc.ofs, acc.data);
		end
		if (acc.acc) rdata_q <= mem[addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
			cmd_byte_q <= '0;
		end else if (ohci_rh_pkg::is_hc_reset(acc)) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
			cmd_byte_q <= acc.data & 8'hfe;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == ohci_rh_pkg::addr_t'(ohci_rh_pkg::STORE_BYTES - 1))
				clr_q <= 1'b0;
		end
	end

endmodule

// File: bench/tb_ohci_root_hub_register_block_top.sv
`timescale 1ns / 1ps
module tb_ohci_root_hub_register_block_top;

	localparam logic CMD_READ  = 1'b0;
	localparam logic CMD_WRITE = 1'b1;
	localparam int   CYCLE_LIMIT = 2000000;
	localparam int   RANDOM_ITEMS = 1950;
	localparam int   MAX_HC_RESETS = 6;

	logic clk;
	logic arst_n;

	ohci_rh_req_if req_ch ();
	ohci_rh_rsp_if rsp_ch ();

	ohci_root_hub_register_block_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// predicted register image
	logic [7:0] hub_image [ohci_rh_pkg::STORE_BYTES];
	logic [7:0] pending_bytes [$];
	int mismatches;
	int accesses_sent;
	int bytes_checked;
	int hc_resets;
	int cycle_count;
	int send_idle_pct;
	int recv_idle_pct;
	int stall_request;
	int stall_left;

	always #10 clk = ~clk;

	function automatic void load_defaults();
		foreach (hub_image[i])
			hub_image[i] = 8'h00;
		hub_image[ohci_rh_pkg::OFS_REV]     = 8'h10;
		hub_image[ohci_rh_pkg::OFS_REV1]    = 8'h01;
		hub_image[ohci_rh_pkg::OFS_DESC_A0] = 8'h02;
	endfunction

	function automatic void drop_port_power(logic [11:0] st);
		hub_image[st + 1] = hub_image[st + 1] & ~8'h01;
		hub_image[st]     = hub_image[st] & ~8'h17;
		hub_image[st + 2] = hub_image[st + 2] & ~8'h17;
	endfunction

	function automatic void run_port_command(logic [11:0] st, logic [7:0] v);
		logic [7:0] prev;
		logic [7:0] now;
		logic [7:0] change;
		prev = hub_image[st];
		now = prev;
		change = hub_image[st + 2];
		if (v[4]) begin
			if (prev[0]) change[4] = 1'b1;
			else change[0] = 1'b1;
		end
		if (v[3]) now[2] = 1'b0;
		if (v[2]) now[2] = 1'b1;
		if (v[1]) begin
			if (prev[0]) now[1] = 1'b1;
			else change[0] = 1'b1;
		end
		if (v[0]) begin
			if (prev[0]) now[1] = 1'b0;
			else change[0] = 1'b1;
		end
		// suspend dropped: resume-complete change
		if (!now[2] && prev[2]) change[2] = 1'b1;
		hub_image[st] = now;
		hub_image[st + 2] = change;
	endfunction

	function automatic logic [7:0] predict_access(logic cmd, logic [11:0] ofs, logic [7:0] v);
		logic [1:0] mode;
		logic [7:0] mask;
		logic [7:0] bitsel;
		if (cmd == CMD_READ)
			return hub_image[ofs];
		mode = hub_image[ohci_rh_pkg::OFS_DESC_A1][1:0];
		mask = hub_image[ohci_rh_pkg::OFS_DESC_B2];
		case (ofs)
			ohci_rh_pkg::OFS_CTRL: begin
				if (v[7:6] == 2'b00) begin
					hub_image[ohci_rh_pkg::OFS_P1_CHG] = 8'h16;
					hub_image[ohci_rh_pkg::OFS_P2_CHG] = 8'h16;
				end
				hub_image[ofs] = v;
			end
			ohci_rh_pkg::OFS_CMD: begin
				if (v[3]) hub_image[ohci_rh_pkg::OFS_INT_ST3] = 8'h40;
				if (v[0]) begin
					load_defaults();
					v[0] = 1'b0;
				end
				hub_image[ofs] = v;
			end
			ohci_rh_pkg::OFS_INT_ST:  hub_image[ofs] = hub_image[ofs] & ~(v & 8'h7f);
			ohci_rh_pkg::OFS_INT_ST3: hub_image[ofs] = hub_image[ofs] & ~(v & 8'h40);
			ohci_rh_pkg::OFS_FM_INT3: hub_image[ofs] = v & 8'h80;
			ohci_rh_pkg::OFS_FM_INT1, ohci_rh_pkg::OFS_PER1: hub_image[ofs] = v & 8'h3f;
			ohci_rh_pkg::OFS_LS1:     hub_image[ofs] = v & 8'h0f;
			ohci_rh_pkg::OFS_INT_EN, ohci_rh_pkg::OFS_INT_EN2, ohci_rh_pkg::OFS_FM_RO2,
			ohci_rh_pkg::OFS_FM_RO6, ohci_rh_pkg::OFS_FM_RO7, ohci_rh_pkg::OFS_PER_RO2,
			ohci_rh_pkg::OFS_PER_RO3, ohci_rh_pkg::OFS_LS_RO2, ohci_rh_pkg::OFS_LS_RO3,
			ohci_rh_pkg::OFS_DESC_A0, ohci_rh_pkg::OFS_DESC_A2, ohci_rh_pkg::OFS_DESC_B1,
			ohci_rh_pkg::OFS_DESC_B3, ohci_rh_pkg::OFS_P1_RO, ohci_rh_pkg::OFS_P2_RO: ;
			ohci_rh_pkg::OFS_DESC_A1: begin
				hub_image[ofs] = v & 8'h1b;
				if (v[1]) begin
					hub_image[ohci_rh_pkg::OFS_P1_PWR][0] = 1'b1;
					hub_image[ohci_rh_pkg::OFS_P2_PWR][0] = 1'b1;
				end
			end
			ohci_rh_pkg::OFS_DESC_A3: hub_image[ofs] = v & 8'h03;
			ohci_rh_pkg::OFS_DESC_B0: begin
				hub_image[ofs] = v & 8'h06;
				if (!v[2]) begin
					if (!hub_image[ohci_rh_pkg::OFS_P2_ST][0])
						hub_image[ohci_rh_pkg::OFS_P2_CHG][0] = 1'b1;
					hub_image[ohci_rh_pkg::OFS_P2_ST][0] = 1'b1;
				end
				if (!v[1]) begin
					if (!hub_image[ohci_rh_pkg::OFS_P1_ST][0])
						hub_image[ohci_rh_pkg::OFS_P1_CHG][0] = 1'b1;
					hub_image[ohci_rh_pkg::OFS_P1_ST][0] = 1'b1;
				end
			end
			ohci_rh_pkg::OFS_DESC_B2: hub_image[ofs] = v & 8'h06;
			ohci_rh_pkg::OFS_HUB_ST0: begin
				if (v[0]) begin
					if (mode == ohci_rh_pkg::MODE_GANGED) begin
						drop_port_power(ohci_rh_pkg::OFS_P1_ST);
						drop_port_power(ohci_rh_pkg::OFS_P2_ST);
					end else if (mode == ohci_rh_pkg::MODE_PERPORT) begin
						if (!mask[1]) drop_port_power(ohci_rh_pkg::OFS_P1_ST);
						if (!mask[2]) drop_port_power(ohci_rh_pkg::OFS_P2_ST);
					end
				end
			end
			ohci_rh_pkg::OFS_HUB_ST1: if (v[7]) hub_image[ofs][7] = 1'b1;
			ohci_rh_pkg::OFS_HUB_ST2: begin
				hub_image[ofs] = hub_image[ofs] & ~(v & 8'h02);
				if (v[0]) begin
					if (mode == ohci_rh_pkg::MODE_GANGED) begin
						hub_image[ohci_rh_pkg::OFS_P1_PWR][0] = 1'b1;
						hub_image[ohci_rh_pkg::OFS_P2_PWR][0] = 1'b1;
					end else if (mode == ohci_rh_pkg::MODE_PERPORT) begin
						if (!mask[1]) hub_image[ohci_rh_pkg::OFS_P1_PWR][0] = 1'b1;
						if (!mask[2]) hub_image[ohci_rh_pkg::OFS_P2_PWR][0] = 1'b1;
					end
				end
			end
			ohci_rh_pkg::OFS_HUB_ST3: if (v[7]) hub_image[ohci_rh_pkg::OFS_HUB_ST1][7] = 1'b0;
			ohci_rh_pkg::OFS_P1_ST, ohci_rh_pkg::OFS_P2_ST: run_port_command(ofs, v);
			ohci_rh_pkg::OFS_P1_PWR, ohci_rh_pkg::OFS_P2_PWR: begin
				bitsel = (ofs == ohci_rh_pkg::OFS_P1_PWR) ? 8'h02 : 8'h04;
				if (mode == ohci_rh_pkg::MODE_GANGED && (mask & bitsel) != 8'h00) begin
					if (v[1]) begin
						if (ofs == ohci_rh_pkg::OFS_P1_PWR)
							drop_port_power(ohci_rh_pkg::OFS_P1_ST);
						else hub_image[ofs][0] = 1'b0;
					end
					if (v[0]) hub_image[ofs][0] = 1'b1;
				end
			end
			ohci_rh_pkg::OFS_P1_CHG, ohci_rh_pkg::OFS_P2_CHG:
				hub_image[ofs] = hub_image[ofs] & ~(v & 8'h1f);
			default: hub_image[ofs] = v;
		endcase
		return 8'h00;
	endfunction

	task automatic access_hub(logic cmd, logic [11:0] ofs, logic [7:0] v);
		int gap;
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			gap = $urandom_range(4, 1);
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.command    <= cmd;
		req_ch.offset     <= ofs;
		req_ch.write_byte <= v;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		pending_bytes.push_back(predict_access(cmd, ofs, v));
		accesses_sent++;
		if (cmd == CMD_WRITE && ofs == ohci_rh_pkg::OFS_CMD && v[0]) hc_resets++;
	endtask

	task automatic rd(logic [11:0] ofs);
		access_hub(CMD_READ, ofs, 8'($urandom_range(255)));
	endtask

	task automatic wr(logic [11:0] ofs, logic [7:0] v);
		access_hub(CMD_WRITE, ofs, v);
	endtask

	task automatic test_identity_and_edges();
		rd(ohci_rh_pkg::OFS_REV);
		rd(ohci_rh_pkg::OFS_REV1);
		rd(ohci_rh_pkg::OFS_DESC_A0);
		wr(12'hfff, 8'hff);
		rd(12'hfff);
		wr(12'h000, 8'h00);
		rd(12'h000);
	endtask

	task automatic test_masked_bytes();
		wr(ohci_rh_pkg::OFS_INT_ST, 8'hff);
		wr(ohci_rh_pkg::OFS_FM_INT1, 8'hff);
		wr(ohci_rh_pkg::OFS_FM_INT3, 8'hff);
		wr(ohci_rh_pkg::OFS_FM_RO2, 8'hff);
		rd(ohci_rh_pkg::OFS_FM_INT3);
		wr(ohci_rh_pkg::OFS_LS1, 8'hff);
		wr(ohci_rh_pkg::OFS_DESC_A3, 8'hff);
		wr(ohci_rh_pkg::OFS_DESC_A0, 8'h55);
		rd(ohci_rh_pkg::OFS_DESC_A0);
		wr(ohci_rh_pkg::OFS_CMD, 8'h08);
		wr(ohci_rh_pkg::OFS_INT_ST3, 8'h40);
		rd(ohci_rh_pkg::OFS_INT_ST3);
	endtask

	task automatic test_port_power();
		wr(ohci_rh_pkg::OFS_DESC_A1, 8'h02);
		wr(ohci_rh_pkg::OFS_DESC_B0, 8'h00);
		wr(ohci_rh_pkg::OFS_CTRL, 8'h00);
		rd(ohci_rh_pkg::OFS_P1_CHG);
		wr(ohci_rh_pkg::OFS_DESC_B2, 8'h06);
		wr(ohci_rh_pkg::OFS_DESC_A1, 8'h00);
		wr(ohci_rh_pkg::OFS_P1_PWR, 8'h02);
		wr(ohci_rh_pkg::OFS_P2_PWR, 8'h03);
		wr(ohci_rh_pkg::OFS_DESC_A1, 8'h01);
		wr(ohci_rh_pkg::OFS_DESC_B2, 8'h02);
		wr(ohci_rh_pkg::OFS_HUB_ST0, 8'h01);
		wr(ohci_rh_pkg::OFS_HUB_ST2, 8'h03);
		wr(ohci_rh_pkg::OFS_HUB_ST1, 8'h80);
		wr(ohci_rh_pkg::OFS_HUB_ST3, 8'h80);
		rd(ohci_rh_pkg::OFS_P2_PWR);
	endtask

	task automatic test_port_commands();
		wr(ohci_rh_pkg::OFS_DESC_B0, 8'h00);
		wr(ohci_rh_pkg::OFS_P1_ST, 8'h16);
		wr(ohci_rh_pkg::OFS_P1_ST, 8'h09);
		wr(ohci_rh_pkg::OFS_P2_ST, 8'h1f);
		wr(ohci_rh_pkg::OFS_P1_CHG, 8'h1f);
		wr(ohci_rh_pkg::OFS_P2_CHG, 8'h0f);
		rd(ohci_rh_pkg::OFS_P2_CHG);
		wr(ohci_rh_pkg::OFS_CMD, 8'h09);
		rd(ohci_rh_pkg::OFS_P1_ST);
		rd(ohci_rh_pkg::OFS_REV);
	endtask

	function automatic logic [11:0] pick_offset();
		if ($urandom_range(99) < 75)
			return 12'($urandom_range(12'h5f));
		return 12'($urandom_range(12'hfff));
	endfunction

	task automatic test_random(int count, int sidle, int ridle);
		logic [11:0] ofs;
		logic [7:0] v;
		send_idle_pct = sidle;
		recv_idle_pct = ridle;
		repeat (count) begin
			ofs = pick_offset();
			v = 8'($urandom_range(255));
			// each controller reset costs a full store sweep, keep them rare
			if (ofs == ohci_rh_pkg::OFS_CMD && v[0] &&
					(hc_resets >= MAX_HC_RESETS || $urandom_range(3) != 0))
				v[0] = 1'b0;
			access_hub($urandom_range(1) ? CMD_WRITE : CMD_READ, ofs, v);
		end
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		stall_request = 300;
		repeat (40) access_hub(1'($urandom_range(1)), pick_offset(), 8'($urandom_range(254)));
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else if (stall_request > 0) begin
			stall_left = stall_request;
			stall_request = 0;
			rsp_ch.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_bytes.size() == 0) begin
				$display("%0t: unexpected read_byte %02h", $time, rsp_ch.read_byte);
				mismatches++;
			end else begin
				if (rsp_ch.read_byte !== pending_bytes[0]) begin
					$display("%0t: read_byte expected %02h actual %02h", $time,
						pending_bytes[0], rsp_ch.read_byte);
					mismatches++;
				end
				void'(pending_bytes.pop_front());
				bytes_checked++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout, %0d results outstanding", pending_bytes.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.command = CMD_READ;
		req_ch.offset = 12'h000;
		req_ch.write_byte = 8'h00;
		rsp_ch.ready = 1'b0;
		mismatches = 0;
		accesses_sent = 0;
		bytes_checked = 0;
		hc_resets = 0;
		cycle_count = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		stall_request = 0;
		stall_left = 0;
		load_defaults();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		test_identity_and_edges();
		test_masked_bytes();
		test_port_power();
		test_port_commands();
		test_random(RANDOM_ITEMS / 3, 11, 82);
		test_random(RANDOM_ITEMS / 3, 82, 11);
		test_backpressure();
		test_random(RANDOM_ITEMS / 3, 0, 0);
		req_ch.valid <= 1'b0;

		while (pending_bytes.size() != 0) @(posedge clk);
		repeat (5) @(posedge clk);

		$display("%0d accesses sent, %0d results checked, %0d controller resets",
			accesses_sent, bytes_checked, hc_resets);
		$display("covered masked, read-only, clear-on-write and port power/command bytes");
		if (mismatches == 0 && pending_bytes.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule

// File: files.f
+incdir+rtl
rtl/ohci_rh_pkg.sv
rtl/ohci_rh_req_if.sv
rtl/ohci_rh_rsp_if.sv
rtl/ohci_rh_regs.sv
rtl/ohci_rh_mem.sv
rtl/ohci_root_hub_register_block_top.sv
bench/tb_ohci_root_hub_register_block_top.sv
